/* src/klex_pkg.sv */
// ----------------------------------------------------------------------------
// klex_pkg
// Shared types and constants for the keyword/number/relop/identifier lexer.
// ----------------------------------------------------------------------------
package klex_pkg;

  localparam int LENGTH_BITS_DEF = 8;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [2:0] {
    CLS_IF      = 3'd0,
    CLS_THEN    = 3'd1,
    CLS_ELSE    = 3'd2,
    CLS_NUMBER  = 3'd3,
    CLS_RELOP   = 3'd4,
    CLS_IDENT   = 3'd5,
    CLS_UNIDENT = 3'd6
  } tok_class_t;

  typedef enum logic [11:0] {
    KW_START = 12'h001,
    KW_I     = 12'h002,
    KW_IF    = 12'h004,
    KW_T     = 12'h008,
    KW_TH    = 12'h010,
    KW_THE   = 12'h020,
    KW_THEN  = 12'h040,
    KW_E     = 12'h080,
    KW_EL    = 12'h100,
    KW_ELS   = 12'h200,
    KW_ELSE  = 12'h400,
    KW_DEAD  = 12'h800
  } kw_state_t;

  typedef enum logic [6:0] {
    NU_START = 7'h01,
    NU_WS    = 7'h02,
    NU_SIGN  = 7'h04,
    NU_INT   = 7'h08,
    NU_DOT   = 7'h10,
    NU_FRAC  = 7'h20,
    NU_DEAD  = 7'h40
  } num_state_t;

  typedef enum logic [5:0] {
    RL_START = 6'h01,
    RL_EQ    = 6'h02,
    RL_LT    = 6'h04,
    RL_GT    = 6'h08,
    RL_PAIR  = 6'h10,
    RL_DEAD  = 6'h20
  } rel_state_t;

  // token closed by the current beat
  typedef struct packed {
    logic       emit;
    tok_class_t token_class;
    logic       length_saturated;
  } tok_res_t;

endpackage

/* src/klex_fsm.sv */
// ----------------------------------------------------------------------------
// klex_fsm
// Per-token recognizers: keyword, number and relop automata, identifier flag
// and saturating length counter, updated once per character beat.
// ----------------------------------------------------------------------------
module klex_fsm #(
  parameter int LENGTH_BITS = klex_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic [7:0]             char_code,
  input  logic                   end_of_line,
  output klex_pkg::tok_res_t     res,
  output logic [LENGTH_BITS-1:0] res_length
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  klex_pkg::kw_state_t  kw_r,  kw_nxt;
  klex_pkg::num_state_t num_r, num_nxt;
  klex_pkg::rel_state_t rel_r, rel_nxt;
  logic                 ident_r, ident_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  klex_pkg::tok_class_t cls;

  logic is_letter, is_digit, is_sign, is_ws, is_space, first, pending;

  assign is_letter = (char_code >= "a" && char_code <= "z") ||
                     (char_code >= "A" && char_code <= "Z");
  assign is_digit  = char_code >= "0" && char_code <= "9";
  assign is_sign   = char_code == "+" || char_code == "-";
  assign is_ws     = char_code == klex_pkg::CH_TAB || char_code == klex_pkg::CH_VT ||
                     char_code == klex_pkg::CH_FF  || char_code == klex_pkg::CH_CR;
  assign is_space  = char_code == klex_pkg::CH_SPACE;
  assign pending   = (count_r != '0) || ovf_r;
  assign first     = !pending;

  always_comb begin
    case (kw_r)
      klex_pkg::KW_START: begin
        if (char_code == "i")      kw_nxt = klex_pkg::KW_I;
        else if (char_code == "t") kw_nxt = klex_pkg::KW_T;
        else if (char_code == "e") kw_nxt = klex_pkg::KW_E;
        else                       kw_nxt = klex_pkg::KW_DEAD;
      end
      klex_pkg::KW_I:   kw_nxt = (char_code == "f") ? klex_pkg::KW_IF   : klex_pkg::KW_DEAD;
      klex_pkg::KW_T:   kw_nxt = (char_code == "h") ? klex_pkg::KW_TH   : klex_pkg::KW_DEAD;
      klex_pkg::KW_TH:  kw_nxt = (char_code == "e") ? klex_pkg::KW_THE  : klex_pkg::KW_DEAD;
      klex_pkg::KW_THE: kw_nxt = (char_code == "n") ? klex_pkg::KW_THEN : klex_pkg::KW_DEAD;
      klex_pkg::KW_E:   kw_nxt = (char_code == "l") ? klex_pkg::KW_EL   : klex_pkg::KW_DEAD;
      klex_pkg::KW_EL:  kw_nxt = (char_code == "s") ? klex_pkg::KW_ELS  : klex_pkg::KW_DEAD;
      klex_pkg::KW_ELS: kw_nxt = (char_code == "e") ? klex_pkg::KW_ELSE : klex_pkg::KW_DEAD;
      default:          kw_nxt = klex_pkg::KW_DEAD;
    endcase
  end

  always_comb begin
    case (num_r)
      klex_pkg::NU_START: begin
        if (is_ws)         num_nxt = klex_pkg::NU_WS;
        else if (is_sign)  num_nxt = klex_pkg::NU_SIGN;
        else if (is_digit) num_nxt = klex_pkg::NU_INT;
        else               num_nxt = klex_pkg::NU_DEAD;
      end
      klex_pkg::NU_WS: begin
        if (is_sign)       num_nxt = klex_pkg::NU_SIGN;
        else if (is_digit) num_nxt = klex_pkg::NU_INT;
        else               num_nxt = klex_pkg::NU_DEAD;
      end
      klex_pkg::NU_SIGN: num_nxt = is_digit ? klex_pkg::NU_INT : klex_pkg::NU_DEAD;
      klex_pkg::NU_INT: begin
        if (is_digit)              num_nxt = klex_pkg::NU_INT;
        else if (char_code == ".") num_nxt = klex_pkg::NU_DOT;
        else                       num_nxt = klex_pkg::NU_DEAD;
      end
      klex_pkg::NU_DOT:  num_nxt = is_digit ? klex_pkg::NU_FRAC : klex_pkg::NU_DEAD;
      klex_pkg::NU_FRAC: num_nxt = is_digit ? klex_pkg::NU_FRAC : klex_pkg::NU_DEAD;
      default:           num_nxt = klex_pkg::NU_DEAD;
    endcase
  end

  always_comb begin
    case (rel_r)
      klex_pkg::RL_START: begin
        if (char_code == "=")      rel_nxt = klex_pkg::RL_EQ;
        else if (char_code == "<") rel_nxt = klex_pkg::RL_LT;
        else if (char_code == ">") rel_nxt = klex_pkg::RL_GT;
        else                       rel_nxt = klex_pkg::RL_DEAD;
      end
      klex_pkg::RL_EQ, klex_pkg::RL_LT, klex_pkg::RL_GT:
        rel_nxt = (char_code == "=") ? klex_pkg::RL_PAIR : klex_pkg::RL_DEAD;
      default: rel_nxt = klex_pkg::RL_DEAD;
    endcase
  end

  assign ident_nxt = first ? is_letter : (ident_r && (is_letter || is_digit));
  assign count_nxt = (count_r == LEN_MAX) ? LEN_MAX : count_r + 1'b1;
  assign ovf_nxt   = ovf_r || (count_r == LEN_MAX);

  // classification by priority over the recognizers
  always_comb begin
    if (kw_r == klex_pkg::KW_IF)
      cls = klex_pkg::CLS_IF;
    else if (kw_r == klex_pkg::KW_THEN)
      cls = klex_pkg::CLS_THEN;
    else if (kw_r == klex_pkg::KW_ELSE)
      cls = klex_pkg::CLS_ELSE;
    else if (num_r == klex_pkg::NU_INT || num_r == klex_pkg::NU_FRAC)
      cls = klex_pkg::CLS_NUMBER;
    else if (rel_r == klex_pkg::RL_EQ || rel_r == klex_pkg::RL_LT ||
             rel_r == klex_pkg::RL_GT || rel_r == klex_pkg::RL_PAIR)
      cls = klex_pkg::CLS_RELOP;
    else if (ident_r)
      cls = klex_pkg::CLS_IDENT;
    else
      cls = klex_pkg::CLS_UNIDENT;
  end

  assign res.token_class      = cls;
  assign res.emit             = step_en && (end_of_line ? pending : is_space);
  assign res.length_saturated = ovf_r;
  assign res_length           = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_r    <= klex_pkg::KW_START;
      num_r   <= klex_pkg::NU_START;
      rel_r   <= klex_pkg::RL_START;
      ident_r <= 1'b0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (step_en) begin
      if (end_of_line || is_space) begin
        kw_r    <= klex_pkg::KW_START;
        num_r   <= klex_pkg::NU_START;
        rel_r   <= klex_pkg::RL_START;
        ident_r <= 1'b0;
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        kw_r    <= kw_nxt;
        num_r   <= num_nxt;
        rel_r   <= rel_nxt;
        ident_r <= ident_nxt;
        count_r <= count_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

endmodule

/* src/keyword_number_relop_id_lexer_core.sv */
// Line lexer taking one character beat per clock. Each accepted beat lands in
// an input register; once the result register is empty or being drained the
// per-token recognizers advance on it and any token it closes is written to
// the result register, so a token beat passes through both registers. With
// the result side ready the block takes one character per cycle; while a
// result beat is stalled the beat in the input register waits, and input
// stalls once that register is full as well.
// A space beat always closes a token (possibly empty); a tlast beat carries no
// character and closes the pending token only if it holds characters.
// ----------------------------------------------------------------------------
// keyword_number_relop_id_lexer_core
// Top level: input register, token recognizers and result register.
// ----------------------------------------------------------------------------
module keyword_number_relop_id_lexer_core #(
  parameter int LENGTH_BITS = klex_pkg::LENGTH_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // end_of_line
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [2:0] out_tuser,  // [2:0] token_class
  // token_length, length_saturated, zero fill
  output logic [((LENGTH_BITS + 1 + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int OUT_W = ((LENGTH_BITS + 1 + 7) / 8) * 8;
  localparam int PAD_W = OUT_W - LENGTH_BITS - 1;

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_eol_r;
  logic       adv;

  klex_pkg::tok_res_t     res;
  logic [LENGTH_BITS-1:0] res_length;

  logic                   out_valid_r;
  klex_pkg::tok_class_t   out_class_r;
  logic [LENGTH_BITS-1:0] out_length_r;
  logic                   out_sat_r;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_eol_r  <= in_tlast;
    end
  end

  klex_fsm #(.LENGTH_BITS(LENGTH_BITS)) u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (adv),
    .char_code   (s1_char_r),
    .end_of_line (s1_eol_r),
    .res         (res),
    .res_length  (res_length)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) begin
      out_class_r  <= res.token_class;
      out_length_r <= res_length;
      out_sat_r    <= res.length_saturated;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_class_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_sat_r, out_length_r};

endmodule

/* src/klex_checker.sv */
// ----------------------------------------------------------------------------
// klex_checker
// Port-level checks on the lexer result stream, bound to the top level.
// ----------------------------------------------------------------------------
module klex_checker #(
  parameter int LENGTH_BITS = klex_pkg::LENGTH_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [2:0] out_tuser,
  input logic [((LENGTH_BITS + 1 + 7) / 8) * 8 - 1:0] out_tdata
);

  logic [2:0]             cls;
  logic [LENGTH_BITS-1:0] len;
  logic                   sat;

  assign cls = out_tuser;
  assign len = out_tdata[LENGTH_BITS-1:0];
  assign sat = out_tdata[LENGTH_BITS];

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_sat_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && sat |-> len == {LENGTH_BITS{1'b1}})
    else $error("saturated token without full length");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !sat && len == '0 |-> cls == klex_pkg::CLS_UNIDENT)
    else $error("empty token not unidentified");

  a_kw_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (cls == klex_pkg::CLS_IF || cls == klex_pkg::CLS_THEN ||
                   cls == klex_pkg::CLS_ELSE || cls == klex_pkg::CLS_RELOP)
    |-> !sat && len != '0 && len <= LENGTH_BITS'(4))
    else $error("keyword or relop with impossible length");

  // a result needs at least one character beat accepted earlier
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a closing beat");

endmodule

bind keyword_number_relop_id_lexer_core klex_checker #(
  .LENGTH_BITS(LENGTH_BITS)
) u_klex_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams character beats into the line lexer and checks every token beat
// against a cycle-free lexer model kept in this file: keywords, numbers,
// relops, identifiers, empty tokens, long tokens and random lines, with
// random idling on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LEN_BITS = 8;
  localparam int OUT_W    = ((LEN_BITS + 1 + 7) / 8) * 8;
  localparam int LIMIT    = 500000;

  typedef struct {
    klex_pkg::tok_class_t cls;
    logic [LEN_BITS-1:0]  len;
    logic                 sat;
  } token_t;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = 8'h00;
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [2:0]       out_tuser;
  logic [OUT_W-1:0] out_tdata;

  // lexer model state for the pending token
  klex_pkg::kw_state_t  kw_st;
  klex_pkg::num_state_t num_st;
  klex_pkg::rel_state_t rel_st;
  logic                 id_ok;
  logic [LEN_BITS-1:0]  tok_len;
  logic                 tok_ovf;

  token_t expected_tokens[$];
  token_t want;
  token_t got;

  int  errors     = 0;
  int  beats_sent = 0;
  int  cycles     = 0;
  bit  tx_idle    = 1'b1;
  bit  rx_idle    = 1'b1;
  int  hold_req   = 0;
  int  hold_left  = 0;
  int  stall_left = 0;

  keyword_number_relop_id_lexer_core #(
    .LENGTH_BITS(LEN_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("keyword_number_relop_id_lexer_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  task automatic clear_token();
    kw_st   = klex_pkg::KW_START;
    num_st  = klex_pkg::NU_START;
    rel_st  = klex_pkg::RL_START;
    id_ok   = 1'b0;
    tok_len = '0;
    tok_ovf = 1'b0;
  endtask

  function automatic klex_pkg::tok_class_t token_kind();
    if (kw_st == klex_pkg::KW_IF) return klex_pkg::CLS_IF;
    if (kw_st == klex_pkg::KW_THEN) return klex_pkg::CLS_THEN;
    if (kw_st == klex_pkg::KW_ELSE) return klex_pkg::CLS_ELSE;
    if (num_st == klex_pkg::NU_INT || num_st == klex_pkg::NU_FRAC)
      return klex_pkg::CLS_NUMBER;
    if (rel_st == klex_pkg::RL_EQ || rel_st == klex_pkg::RL_LT ||
        rel_st == klex_pkg::RL_GT || rel_st == klex_pkg::RL_PAIR)
      return klex_pkg::CLS_RELOP;
    if (id_ok) return klex_pkg::CLS_IDENT;
    return klex_pkg::CLS_UNIDENT;
  endfunction

  task automatic lex_beat(input logic [7:0] code, input logic eol);
    token_t t;
    logic   fresh;
    logic   dig;
    logic   alpha;
    logic   sgn;
    logic   ws;
    if (eol || code == klex_pkg::CH_SPACE) begin
      // a space always closes a token, end of line only a non-empty one
      if (!eol || tok_len != 0 || tok_ovf) begin
        t.cls = token_kind();
        t.len = tok_len;
        t.sat = tok_ovf;
        expected_tokens.insert(expected_tokens.size(), t);
      end
      clear_token();
    end else begin
      fresh = (tok_len == 0 && !tok_ovf);
      dig   = (code >= "0" && code <= "9");
      alpha = (code >= "a" && code <= "z") || (code >= "A" && code <= "Z");
      sgn   = (code == "+" || code == "-");
      ws    = (code == klex_pkg::CH_TAB || code == klex_pkg::CH_VT ||
               code == klex_pkg::CH_FF || code == klex_pkg::CH_CR);
      case (kw_st)
        klex_pkg::KW_START: begin
          if (code == "i") kw_st = klex_pkg::KW_I;
          else if (code == "t") kw_st = klex_pkg::KW_T;
          else if (code == "e") kw_st = klex_pkg::KW_E;
          else kw_st = klex_pkg::KW_DEAD;
        end
        klex_pkg::KW_I:   kw_st = (code == "f") ? klex_pkg::KW_IF   : klex_pkg::KW_DEAD;
        klex_pkg::KW_T:   kw_st = (code == "h") ? klex_pkg::KW_TH   : klex_pkg::KW_DEAD;
        klex_pkg::KW_TH:  kw_st = (code == "e") ? klex_pkg::KW_THE  : klex_pkg::KW_DEAD;
        klex_pkg::KW_THE: kw_st = (code == "n") ? klex_pkg::KW_THEN : klex_pkg::KW_DEAD;
        klex_pkg::KW_E:   kw_st = (code == "l") ? klex_pkg::KW_EL   : klex_pkg::KW_DEAD;
        klex_pkg::KW_EL:  kw_st = (code == "s") ? klex_pkg::KW_ELS  : klex_pkg::KW_DEAD;
        klex_pkg::KW_ELS: kw_st = (code == "e") ? klex_pkg::KW_ELSE : klex_pkg::KW_DEAD;
        default: kw_st = klex_pkg::KW_DEAD;
      endcase
      case (num_st)
        klex_pkg::NU_START: begin
          if (ws) num_st = klex_pkg::NU_WS;
          else if (sgn) num_st = klex_pkg::NU_SIGN;
          else num_st = dig ? klex_pkg::NU_INT : klex_pkg::NU_DEAD;
        end
        klex_pkg::NU_WS: begin
          if (sgn) num_st = klex_pkg::NU_SIGN;
          else num_st = dig ? klex_pkg::NU_INT : klex_pkg::NU_DEAD;
        end
        klex_pkg::NU_SIGN: num_st = dig ? klex_pkg::NU_INT : klex_pkg::NU_DEAD;
        klex_pkg::NU_INT: begin
          if (dig) num_st = klex_pkg::NU_INT;
          else num_st = (code == ".") ? klex_pkg::NU_DOT : klex_pkg::NU_DEAD;
        end
        klex_pkg::NU_DOT, klex_pkg::NU_FRAC:
          num_st = dig ? klex_pkg::NU_FRAC : klex_pkg::NU_DEAD;
        default: num_st = klex_pkg::NU_DEAD;
      endcase
      case (rel_st)
        klex_pkg::RL_START: begin
          if (code == "=") rel_st = klex_pkg::RL_EQ;
          else if (code == "<") rel_st = klex_pkg::RL_LT;
          else if (code == ">") rel_st = klex_pkg::RL_GT;
          else rel_st = klex_pkg::RL_DEAD;
        end
        klex_pkg::RL_EQ, klex_pkg::RL_LT, klex_pkg::RL_GT:
          rel_st = (code == "=") ? klex_pkg::RL_PAIR : klex_pkg::RL_DEAD;
        default: rel_st = klex_pkg::RL_DEAD;
      endcase
      if (fresh) id_ok = alpha;
      else id_ok = id_ok && (alpha || dig);
      if (tok_len == '1) tok_ovf = 1'b1;
      else tok_len = tok_len + 1'b1;
    end
  endtask

  // ------------------------------------------------------- stimulus side

  // called at a falling edge, returns at the falling edge after the handshake
  task automatic send_beat(input logic [7:0] code, input logic eol);
    int gap;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tlast  <= eol;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_beat(code, eol);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic end_line();
    // the data byte of a tlast beat is meaningless, so make it noise
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_run(input logic [7:0] code, input int n);
    for (int i = 0; i < n; i++) send_beat(code, 1'b0);
  endtask

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_alnum();
    return $urandom_range(0, 2) == 0 ? pick_digit() : pick_letter();
  endfunction

  task automatic send_random_token();
    int    n;
    string kw[3]  = '{"if", "then", "else"};
    string nkw[8] = '{"i", "th", "els", "iff", "thenx", "If", "ELSE", "elsif"};
    string rel[6] = '{"=", "<", ">", "<=", ">=", "=="};
    string nrel[6] = '{"=<", "===", "<>", "!=", "<<", ">=="};
    string nnum[7] = '{"+", "-.", "1.", ".5", "1.2.3", "1e5", "+-3"};
    case ($urandom_range(0, 10))
      0: send_str(kw[$urandom_range(0, 2)]);
      1: send_str(nkw[$urandom_range(0, 7)]);
      2, 3: begin
        case ($urandom_range(0, 7))
          0: send_beat(klex_pkg::CH_TAB, 1'b0);
          1: send_beat(klex_pkg::CH_VT, 1'b0);
          2: send_beat(klex_pkg::CH_FF, 1'b0);
          3: send_beat(klex_pkg::CH_CR, 1'b0);
          4: send_beat(8'h0a, 1'b0);  // line feed does not lead a number
          default: ;
        endcase
        case ($urandom_range(0, 3))
          0: send_beat("+", 1'b0);
          1: send_beat("-", 1'b0);
          default: ;
        endcase
        n = $urandom_range(1, 6);
        repeat (n) send_beat(pick_digit(), 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          send_beat(".", 1'b0);
          n = $urandom_range(0, 4);
          repeat (n) send_beat(pick_digit(), 1'b0);
        end
      end
      4: send_str(nnum[$urandom_range(0, 6)]);
      5: send_str(rel[$urandom_range(0, 5)]);
      6: send_str(nrel[$urandom_range(0, 5)]);
      7: begin
        send_beat(pick_letter(), 1'b0);
        n = $urandom_range(0, 8);
        repeat (n) send_beat(pick_alnum(), 1'b0);
      end
      8: begin
        if ($urandom_range(0, 1)) send_beat(pick_digit(), 1'b0);
        else send_beat("_", 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) send_beat(pick_alnum(), 1'b0);
        if ($urandom_range(0, 1)) send_beat("_", 1'b0);
      end
      9: begin
        n = $urandom_range(1, 6);
        repeat (n) send_beat(8'($urandom_range(0, 255)), 1'b0);
      end
      default: ;  // empty token
    endcase
  endtask

  task automatic send_random_line_piece();
    int n;
    // a rare token near or past the length limit
    if ($urandom_range(0, 149) == 0) begin
      n = $urandom_range(250, 262);
      if ($urandom_range(0, 1)) begin
        send_beat(pick_letter(), 1'b0);
        repeat (n - 1) send_beat(pick_alnum(), 1'b0);
      end else begin
        repeat (n) send_beat(pick_digit(), 1'b0);
      end
    end else begin
      send_random_token();
    end
    case ($urandom_range(0, 9))
      7, 8: end_line();
      9: begin
        send_beat(klex_pkg::CH_SPACE, 1'b0);
        end_line();
      end
      default: send_beat(klex_pkg::CH_SPACE, 1'b0);
    endcase
  endtask

  // ------------------------------------------------------- result side

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.cls = klex_pkg::tok_class_t'(out_tuser);
      got.len = out_tdata[0 +: LEN_BITS];
      got.sat = out_tdata[LEN_BITS];
      if (expected_tokens.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: token beat with none pending: class %0d length %0d sat %0b",
                   $time, got.cls, got.len, got.sat);
      end else begin
        want = expected_tokens.pop_front();
        if (got.cls !== want.cls || got.len !== want.len || got.sat !== want.sat) begin
          errors++;
          if (errors <= 10)
            $display("%0t: token mismatch: class %0d/%0d length %0d/%0d sat %0b/%0b (exp/got)",
                     $time, want.cls, got.cls, want.len, got.len, want.sat, got.sat);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_keywords();
    send_str("if then else If elsex");
    end_line();
  endtask

  task automatic test_numbers_and_relops();
    send_beat(klex_pkg::CH_TAB, 1'b0);
    send_str("-12.5 +7 0.25 1. <= >= == = < > =< x");
    end_line();
  endtask

  task automatic test_empty_and_odd_bytes();
    // leading and double spaces give empty tokens, a bare end of line gives none
    send_str("  a9 ");
    end_line();
    end_line();
    send_beat(8'h00, 1'b0);
    send_beat(klex_pkg::CH_SPACE, 1'b0);
    send_beat(8'h0a, 1'b0);
    send_str("5 ");
    send_beat(8'hff, 1'b0);
    send_beat(8'h80, 1'b0);
    end_line();
  endtask

  task automatic test_long_tokens();
    send_run("a", 255);
    send_beat(klex_pkg::CH_SPACE, 1'b0);
    send_run("7", 256);
    end_line();
    send_beat("q", 1'b0);
    send_run("1", 299);
    send_beat("!", 1'b0);
    end_line();
  endtask

  task automatic test_random(input int n_beats);
    int stop_at;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) send_random_line_piece();
  endtask

  task automatic test_backpressure();
    int stop_at;
    // sender keeps offering beats while the receiver holds off
    tx_idle  = 1'b0;
    hold_req = 150;
    stop_at = beats_sent + 80;
    while (beats_sent < stop_at) send_random_line_piece();
    tx_idle  = 1'b1;
  endtask

  initial begin
    clear_token();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_keywords();
    test_numbers_and_relops();
    test_empty_and_odd_bytes();
    test_long_tokens();
    test_random(300);
    test_backpressure();
    // closing stretch at full rate on both sides
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random(150);
    end_line();
    in_tvalid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("keyword_number_relop_id_lexer_core test passed");
    end else begin
      $display("keyword_number_relop_id_lexer_core test failed");
    end
    $finish;
  end

endmodule
